// ===== hdl/rc4_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types for the RC4 cipher: controller states, datapath commands and
// datapath status.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int unsigned PERM_DEPTH = 256;
    localparam int unsigned BYTE_W     = 8;

    typedef enum logic [3:0] {
        ST_BOOT,
        ST_IDLE,
        ST_FILL,
        ST_MIX_RD,
        ST_MIX_ADD,
        ST_MIX_WRN,
        ST_MIX_WRM,
        ST_GEN_J,
        ST_GEN_SWAPI,
        ST_GEN_SWAPJ,
        ST_HOLD
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_FILL,
        OP_KEY_LOAD,
        OP_GEN_START,
        OP_GEN_J,
        OP_GEN_SWAPI,
        OP_GEN_SWAPJ,
        OP_MIX_RD,
        OP_MIX_ADD,
        OP_MIX_WRN,
        OP_MIX_WRM
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit_now;   // load result straight into the output register
        logic   emit_pend;  // load the parked result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_last;     // sweep counter at its final entry
        logic out_free;     // output register can take a result this cycle
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/rc4_stream_cipher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher: key loading, key schedule and byte-wise keystream XOR.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per byte.
//   operation = 0 stores key_byte; key_last on such a transaction starts the
//   key schedule. operation = 1 encrypts/decrypts data_byte; the result
//   appears on the output channel (out_valid/out_ready) as out_byte.
//   Key transactions return nothing. Key bytes past KEY_MAX_BYTES are dropped.
// Sequence:
//   Data byte: result registered after the generator steps, set by the
//   chain of dependent permutation reads and the two swap writes through
//   the single write port of the permutation memory; no new byte until then.
//   Key byte: stored without leaving idle. Final key byte: identity fill, then
//   a mixing pass (read, add, two writes per entry), in_ready low throughout.
// Reset:
//   After rst_n releases, a pass writes the identity permutation;
//   in_ready stays low until it finishes. Indices and key count clear.
// Stall:
//   The output register frees the input side, so a new transaction is taken
//   while a result waits; if the next result is ready before the previous one
//   is taken, the block parks it and holds in_ready low until out_ready.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
    parameter int unsigned KEY_MAX_BYTES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       operation,
    input  wire logic [7:0] key_byte,
    input  wire logic       key_last,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte
);
    import rc4_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: owns all timing, issues one datapath command per cycle
    rc4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .key_last  (key_last),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // datapath: memories, indices and the output register
    rc4_dp #(.KEY_MAX_BYTES(KEY_MAX_BYTES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .key_byte  (key_byte),
        .data_byte (data_byte),
        .out_ready (out_ready),
        .stat      (stat),
        .out_valid (out_valid),
        .out_byte  (out_byte)
    );

    // data transaction keeps the input side busy for the generator steps
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation) |=> !in_ready)
        else $error("input taken during keystream step");

    // final key byte starts the schedule; no input until it completes
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !operation && key_last) |=> !in_ready)
        else $error("input taken during key schedule");

    // plain key byte is stored without leaving idle
    a_key_store: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !operation && !key_last) |=> in_ready)
        else $error("key byte store did not return to idle");

endmodule
`default_nettype wire

// ===== hdl/rc4_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hdl/rc4_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer: boot fill, key load, key schedule and keystream steps.
// ----------------------------------------------------------------------------
module rc4_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              operation,
    input  wire logic              key_last,
    input  wire rc4_pkg::dp_stat_t stat,
    output logic                   in_ready,
    output rc4_pkg::dp_cmd_t       cmd
);
    import rc4_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_BOOT:      if (stat.cnt_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation)     state_next = ST_GEN_J;
                    else if (key_last) state_next = ST_FILL;
                end
            end
            ST_FILL:      if (stat.cnt_last) state_next = ST_MIX_RD;
            ST_MIX_RD:    state_next = ST_MIX_ADD;
            ST_MIX_ADD:   state_next = ST_MIX_WRN;
            ST_MIX_WRN:   state_next = ST_MIX_WRM;
            ST_MIX_WRM:   state_next = stat.cnt_last ? ST_IDLE : ST_MIX_RD;
            ST_GEN_J:     state_next = ST_GEN_SWAPI;
            ST_GEN_SWAPI: state_next = ST_GEN_SWAPJ;
            ST_GEN_SWAPJ: state_next = stat.out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD:      if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd.op        = OP_IDLE;
        cmd.emit_now  = 1'b0;
        cmd.emit_pend = 1'b0;
        case (state_reg)
            ST_BOOT,
            ST_FILL:      cmd.op = OP_FILL;
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = operation ? OP_GEN_START : OP_KEY_LOAD;
                end
            end
            ST_MIX_RD:    cmd.op = OP_MIX_RD;
            ST_MIX_ADD:   cmd.op = OP_MIX_ADD;
            ST_MIX_WRN:   cmd.op = OP_MIX_WRN;
            ST_MIX_WRM:   cmd.op = OP_MIX_WRM;
            ST_GEN_J:     cmd.op = OP_GEN_J;
            ST_GEN_SWAPI: cmd.op = OP_GEN_SWAPI;
            ST_GEN_SWAPJ:
            begin
                cmd.op       = OP_GEN_SWAPJ;
                cmd.emit_now = stat.out_free;
            end
            ST_HOLD:      cmd.emit_pend = stat.out_free;
            default:      cmd.op = OP_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/rc4_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_dp
// Datapath: permutation and key memories, indices, swap registers, output
// register.
// ----------------------------------------------------------------------------
module rc4_dp #(
    parameter int unsigned KEY_MAX_BYTES = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rc4_pkg::dp_cmd_t cmd,
    input  wire logic [7:0]       key_byte,
    input  wire logic [7:0]       data_byte,
    input  wire logic             out_ready,
    output rc4_pkg::dp_stat_t     stat,
    output logic                  out_valid,
    output logic [7:0]            out_byte
);
    import rc4_pkg::*;

    localparam int unsigned KEY_AW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam int unsigned KCW    = $clog2(KEY_MAX_BYTES + 1);

    // control state
    logic [7:0]        n_reg,         n_next;
    logic [KCW-1:0]    key_count_reg, key_count_next;
    logic [7:0]        i_reg,         i_next;
    logic [7:0]        j_reg,         j_next;
    logic              out_valid_reg, out_valid_next;
    // payload
    logic [7:0]        mix_reg,       mix_next;
    logic [KEY_AW-1:0] kidx_reg,      kidx_next;
    logic [7:0]        si_reg,        si_next;
    logic [7:0]        sj_reg,        sj_next;
    logic [7:0]        pos_reg,       pos_next;
    logic [7:0]        data_reg,      data_next;
    logic [7:0]        pend_reg,      pend_next;
    logic [7:0]        out_byte_reg,  out_byte_next;

    // memory ports
    logic              perm_we;
    logic [7:0]        perm_waddr;
    logic [7:0]        perm_wdata;
    logic [7:0]        perm_raddr;
    logic [7:0]        perm_rdata;
    logic              key_we;
    logic [7:0]        key_rdata;

    logic [7:0]        ks;
    logic [7:0]        result;

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_MAX_BYTES)) u_key (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_count_reg[KEY_AW-1:0]),
        .wdata (key_byte),
        .raddr (kidx_reg),
        .rdata (key_rdata)
    );

    assign key_we = (cmd.op == OP_KEY_LOAD) && (key_count_reg < KCW'(KEY_MAX_BYTES));

    // swap touches i and j, so the lookup read issued alongside needs a bypass
    assign ks = (pos_reg == i_reg) ? sj_reg :
                (pos_reg == j_reg) ? si_reg : perm_rdata;
    assign result = data_reg ^ ks;

    assign stat.cnt_last = (n_reg == 8'hFF);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        n_next         = n_reg;
        key_count_next = key_count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        mix_next       = mix_reg;
        kidx_next      = kidx_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        pos_next       = pos_reg;
        data_next      = data_reg;
        pend_next      = pend_reg;
        perm_we        = 1'b0;
        perm_waddr     = n_reg;
        perm_wdata     = n_reg;
        perm_raddr     = n_reg;
        case (cmd.op)
            OP_FILL:
            begin
                perm_we   = 1'b1;
                n_next    = n_reg + 8'd1;
                mix_next  = '0;
                kidx_next = '0;
            end
            OP_KEY_LOAD:
            begin
                if (key_we)
                begin
                    key_count_next = key_count_reg + KCW'(1);
                end
            end
            OP_MIX_RD:
            begin
                perm_raddr = n_reg;
            end
            OP_MIX_ADD:
            begin
                si_next    = perm_rdata;
                mix_next   = mix_reg + perm_rdata + key_rdata;
                perm_raddr = mix_next;
            end
            OP_MIX_WRN:
            begin
                perm_we    = 1'b1;
                perm_waddr = n_reg;
                perm_wdata = perm_rdata;
            end
            OP_MIX_WRM:
            begin
                perm_we    = 1'b1;
                perm_waddr = mix_reg;
                perm_wdata = si_reg;
                n_next     = n_reg + 8'd1;
                if (KCW'(kidx_reg) + KCW'(1) == key_count_reg)
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + KEY_AW'(1);
                end
                if (n_reg == 8'hFF)
                begin
                    i_next         = '0;
                    j_next         = '0;
                    key_count_next = '0;
                end
            end
            OP_GEN_START:
            begin
                i_next     = i_reg + 8'd1;
                perm_raddr = i_next;
                data_next  = data_byte;
            end
            OP_GEN_J:
            begin
                si_next    = perm_rdata;
                j_next     = j_reg + perm_rdata;
                perm_raddr = j_next;
            end
            OP_GEN_SWAPI:
            begin
                sj_next    = perm_rdata;
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rdata;
                pos_next   = si_reg + perm_rdata;
                perm_raddr = pos_next;
            end
            OP_GEN_SWAPJ:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                pend_next  = result;
            end
            default:
            begin
                perm_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        if (cmd.emit_now)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = result;
        end
        else if (cmd.emit_pend)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            key_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            key_count_reg <= key_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg      <= mix_next;
        kidx_reg     <= kidx_next;
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        pos_reg      <= pos_next;
        data_reg     <= data_next;
        pend_reg     <= pend_next;
        out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule
`default_nettype wire
